FILE: hdl/sxt_pkg.sv
// Shared types and constants of the session expiry table.
`default_nettype none

package sxt_pkg;

  localparam int KeyW     = 16;
  localparam int TmoW     = 32;
  localparam int TimeW    = 48;
  localparam int YieldW   = 16;
  localparam int ActW     = 2;
  localparam int StatW    = 3;
  localparam int InDataW  = 96;
  localparam int OutDataW = 120;

  localparam logic [TimeW-1:0]  TimeMax       = '1;
  localparam logic [YieldW-1:0] MinYieldReset = 16'd100;

  // Request kinds carried in the input tuser
  localparam logic [ActW-1:0] ACT_WATCH  = 2'd0;
  localparam logic [ActW-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ActW-1:0] ACT_TICK   = 2'd2;

  // Result status carried in the output tuser
  localparam logic [StatW-1:0] ST_INSERTED  = 3'd0;
  localparam logic [StatW-1:0] ST_REFRESHED = 3'd1;
  localparam logic [StatW-1:0] ST_FULL      = 3'd2;
  localparam logic [StatW-1:0] ST_REMOVED   = 3'd3;
  localparam logic [StatW-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [StatW-1:0] ST_EXPIRED   = 3'd5;
  localparam logic [StatW-1:0] ST_NONE_EXP  = 3'd6;

  // One table slot as it travels around the ring
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] expiry;
  } entry_t;

endpackage

`default_nettype wire

FILE: hdl/sxt_cell.sv
// One slot cell of the rotating table ring.
`default_nettype none

module sxt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  sxt_pkg::entry_t ent_i,
  input  logic            wr_i,
  input  sxt_pkg::entry_t wr_ent_i,
  output sxt_pkg::entry_t ent_o
);
  import sxt_pkg::*;

  logic             valid_q;
  logic             hit_q;
  logic [KeyW-1:0]  key_q;
  logic [TimeW-1:0] expiry_q;
  entry_t           ent_d;
  logic             load;

  assign ent_d = wr_i ? wr_ent_i : ent_i;
  assign load  = wr_i || shift_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else if (load) begin
      valid_q <= ent_d.valid;
      hit_q   <= ent_d.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      key_q    <= ent_d.key;
      expiry_q <= ent_d.expiry;
    end
  end

  assign ent_o = '{valid: valid_q, hit: hit_q, key: key_q, expiry: expiry_q};

endmodule

`default_nettype wire

FILE: hdl/session_expiry_table.sv
// Session expiry table: a ring of key/expiry slot cells and its scan control.
//
// Requests enter on the s_axis channel: tuser is the kind (watch, remove,
// tick), tdata carries key, timeout and current time. Results leave on
// m_axis: tuser is the status, tdata the key, next wakeup, sleep time and
// early-wake flag, tlast marks the final result of a request. The minimum
// sleep time is written through cfg_we_i / cfg_wdata_i; the user writes it
// only while idle, the block itself does not enforce this. Each request
// rotates the whole slot ring once past a single head unit, one slot per
// cycle, so a watch, remove or tick that expires nothing passes the scan,
// store, report and send states; send loads its result into the output
// register and returns to idle, where the next request can be taken. A
// tick that expires entries rotates the ring a second time, frozen while
// the receiver stalls, to hand out the expired keys in slot order.
// One request is in work at a time; s_axis_tready is high only while idle,
// and the next request is taken even while the last result still waits in
// the output register. A stalled receiver holds the result in that register;
// the block waits before loading its next result, with the ring frozen.
// Reset empties the table at once and sets the minimum sleep to 100 ms; no
// clearing pass is needed.
`default_nettype none

module session_expiry_table #(
  parameter int ENTRIES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // key[15:0], timeout_ms[47:16], now_ms[95:48]
  input  logic [sxt_pkg::InDataW-1:0]  s_axis_tdata,
  // action[1:0]
  input  logic [sxt_pkg::ActW-1:0]     s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // key_out[15:0], next_wakeup_ms[63:16], next_valid[64], sleep_ms[112:65],
  // wake_early[113], zero[119:114]
  output logic [sxt_pkg::OutDataW-1:0] m_axis_tdata,
  // status[2:0]
  output logic [sxt_pkg::StatW-1:0]    m_axis_tuser,
  output logic                         m_axis_tlast,
  input  logic                         cfg_we_i,
  input  logic [sxt_pkg::YieldW-1:0]   cfg_wdata_i
);
  import sxt_pkg::*;

  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CntW = $clog2(ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);
  localparam logic [CntW-1:0] OneHit  = CntW'(1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_STORE, S_REPORT, S_SEND, S_EMIT
  } state_e;

  state_e state_q;

  logic [ActW-1:0]   act_q;
  logic [KeyW-1:0]   key_q;
  logic [TimeW-1:0]  now_q;
  logic [TimeW-1:0]  exp_q;
  logic [IdxW-1:0]   cnt_q;
  logic              found_q;
  logic              free_q;
  logic [IdxW-1:0]   free_idx_q;
  logic [TimeW-1:0]  min_q;
  logic              any_q;
  logic [CntW-1:0]   hits_q;
  logic [StatW-1:0]  status_q;
  logic              early_q;
  logic [TimeW-1:0]  sleep_q;
  logic [TimeW-1:0]  next_wakeup_q;
  logic [YieldW-1:0] yield_floor_q;

  logic              out_valid_q;
  logic [StatW-1:0]  out_status_q;
  logic [KeyW-1:0]   out_key_q;
  logic [TimeW-1:0]  out_when_q;
  logic              out_any_q;
  logic [TimeW-1:0]  out_sleep_q;
  logic              out_early_q;
  logic              out_last_q;

  logic [KeyW-1:0]   in_key;
  logic [TmoW-1:0]   in_tmo;
  logic [TimeW-1:0]  in_now;
  logic              in_known;
  logic [TimeW:0]    exp_sum;
  logic [TimeW-1:0]  exp_sat;

  entry_t            cell_ent [ENTRIES];
  entry_t            head;
  entry_t            head_mod;
  entry_t            ins_ent;
  logic              ins_we;
  logic              ring_shift;
  logic              out_free;
  logic              out_load;
  logic              key_hit;
  logic              expired;
  logic              keep;

  logic [TimeW:0]    diff;
  logic [TimeW-1:0]  wait_ms;
  logic [TimeW-1:0]  sleep_d;

  // Input fields and saturated expiry
  assign in_key   = s_axis_tdata[KeyW-1:0];
  assign in_tmo   = s_axis_tdata[KeyW +: TmoW];
  assign in_now   = s_axis_tdata[KeyW+TmoW +: TimeW];
  assign in_known = (s_axis_tuser == ACT_WATCH) || (s_axis_tuser == ACT_REMOVE) ||
                    (s_axis_tuser == ACT_TICK);
  assign exp_sum  = {1'b0, in_now} + (TimeW+1)'(in_tmo);
  assign exp_sat  = exp_sum[TimeW] ? TimeMax : exp_sum[TimeW-1:0];

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  // Slot ring: every cell takes its upper neighbor, the top cell takes the updated head
  assign head    = cell_ent[0];
  assign ins_we  = (state_q == S_STORE) && (act_q == ACT_WATCH) && !found_q && free_q;
  assign ins_ent = '{valid: 1'b1, hit: 1'b0, key: key_q, expiry: exp_q};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t nb;
    if (i == ENTRIES - 1) begin : g_top
      assign nb = head_mod;
    end else begin : g_mid
      assign nb = cell_ent[i+1];
    end
    sxt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (ring_shift),
      .ent_i    (nb),
      .wr_i     (ins_we && (free_idx_q == IdxW'(i))),
      .wr_ent_i (ins_ent),
      .ent_o    (cell_ent[i])
    );
  end

  // Head unit: examine the slot leaving the ring and update it
  assign key_hit = head.valid && (head.key == key_q);
  assign expired = head.valid && (head.expiry <= now_q);

  always_comb begin
    head_mod = head;
    keep     = head.valid;
    if (state_q == S_EMIT) begin
      head_mod.hit = 1'b0;
    end else begin
      case (act_q)
        ACT_WATCH: begin
          if (key_hit) begin
            head_mod.expiry = exp_q;
            keep            = 1'b0;
          end
        end
        ACT_REMOVE: begin
          if (key_hit) begin
            head_mod.valid = 1'b0;
            keep           = 1'b0;
          end
        end
        ACT_TICK: begin
          if (expired) begin
            head_mod.valid = 1'b0;
            head_mod.hit   = 1'b1;
            keep           = 1'b0;
          end
        end
        default: begin
          keep = 1'b0;
        end
      endcase
    end
  end

  // Hold the ring while an expired key waits for the output register
  assign ring_shift = (state_q == S_SCAN) ||
                      ((state_q == S_EMIT) && (!head.hit || out_free));

  assign out_load = ((state_q == S_SEND) && out_free) ||
                    ((state_q == S_EMIT) && ring_shift && head.hit);

  // Sleep time: earliest expiry minus now, clamped below by the minimum yield
  always_comb begin
    diff    = {1'b0, min_q} - {1'b0, now_q};
    wait_ms = (any_q && !diff[TimeW] && (diff[TimeW-1:0] != '0)) ? diff[TimeW-1:0] : '0;
    sleep_d = (wait_ms < TimeW'(yield_floor_q)) ? TimeW'(yield_floor_q) : wait_ms;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      act_q         <= ACT_WATCH;
      key_q         <= '0;
      now_q         <= '0;
      exp_q         <= '0;
      cnt_q         <= '0;
      found_q       <= 1'b0;
      free_q        <= 1'b0;
      free_idx_q    <= '0;
      min_q         <= TimeMax;
      any_q         <= 1'b0;
      hits_q        <= '0;
      status_q      <= ST_INSERTED;
      early_q       <= 1'b0;
      sleep_q       <= '0;
      next_wakeup_q <= '0;
      yield_floor_q <= MinYieldReset;
      out_valid_q   <= 1'b0;
      out_status_q  <= ST_INSERTED;
      out_key_q     <= '0;
      out_when_q    <= '0;
      out_any_q     <= 1'b0;
      out_sleep_q   <= '0;
      out_early_q   <= 1'b0;
      out_last_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        yield_floor_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          // drop the unused request kind without a result
          if (s_axis_tvalid && in_known) begin
            act_q      <= s_axis_tuser;
            key_q      <= in_key;
            now_q      <= in_now;
            exp_q      <= exp_sat;
            cnt_q      <= '0;
            found_q    <= 1'b0;
            free_q     <= 1'b0;
            free_idx_q <= '0;
            min_q      <= TimeMax;
            any_q      <= 1'b0;
            hits_q     <= '0;
            state_q    <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (key_hit && (act_q != ACT_TICK)) begin
            found_q <= 1'b1;
          end
          if ((act_q == ACT_WATCH) && !head.valid && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= cnt_q;
          end
          if ((act_q == ACT_TICK) && expired) begin
            hits_q <= hits_q + OneHit;
          end
          if (keep && (head.expiry <= min_q)) begin
            min_q <= head.expiry;
            any_q <= 1'b1;
          end
          if (cnt_q == LastIdx) begin
            cnt_q   <= '0;
            state_q <= S_STORE;
          end else begin
            cnt_q <= cnt_q + IdxW'(1);
          end
        end

        S_STORE: begin
          early_q <= (act_q == ACT_WATCH) && (found_q || free_q) &&
                     (exp_q < next_wakeup_q);
          case (act_q)
            ACT_WATCH: begin
              if (found_q) begin
                status_q <= ST_REFRESHED;
              end else if (free_q) begin
                status_q <= ST_INSERTED;
              end else begin
                status_q <= ST_FULL;
              end
              if (found_q || free_q) begin
                any_q <= 1'b1;
                if (exp_q <= min_q) begin
                  min_q <= exp_q;
                end
              end
            end
            ACT_REMOVE: begin
              status_q <= found_q ? ST_REMOVED : ST_NOT_FOUND;
            end
            default: begin
              status_q      <= (hits_q == '0) ? ST_NONE_EXP : ST_EXPIRED;
              next_wakeup_q <= any_q ? min_q : TimeMax;
            end
          endcase
          state_q <= S_REPORT;
        end

        S_REPORT: begin
          sleep_q <= sleep_d;
          state_q <= ((act_q == ACT_TICK) && (hits_q != '0)) ? S_EMIT : S_SEND;
        end

        S_SEND: begin
          if (out_free) begin
            out_status_q <= status_q;
            out_key_q    <= (act_q == ACT_TICK) ? '0 : key_q;
            out_when_q   <= any_q ? min_q : '0;
            out_any_q    <= any_q;
            out_sleep_q  <= sleep_q;
            out_early_q  <= early_q;
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end

        S_EMIT: begin
          if (ring_shift) begin
            if (head.hit) begin
              out_status_q <= ST_EXPIRED;
              out_key_q    <= head.key;
              out_when_q   <= any_q ? min_q : '0;
              out_any_q    <= any_q;
              out_sleep_q  <= sleep_q;
              out_early_q  <= 1'b0;
              out_last_q   <= (hits_q == OneHit);
              hits_q       <= hits_q - OneHit;
            end
            // finish the rotation so every slot is back in its own cell
            if (cnt_q == LastIdx) begin
              cnt_q   <= '0;
              state_q <= S_IDLE;
            end else begin
              cnt_q <= cnt_q + IdxW'(1);
            end
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OutDataW-KeyW-2*TimeW-2){1'b0}}, out_early_q, out_sleep_q,
                          out_any_q, out_when_q, out_key_q};

endmodule

`default_nettype wire

FILE: hdl/sxt_checker.sv
// Port-level checks of the session expiry table and their bind.
`default_nettype none

module sxt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [sxt_pkg::ActW-1:0]     s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [sxt_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [sxt_pkg::StatW-1:0]    m_axis_tuser,
  input logic                         m_axis_tlast
);
  import sxt_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Only expired keys come in runs of more than one result
  a_run_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == ST_EXPIRED)
    else $error("non-final result that is not an expiry");

  // No new request while a run of expired keys is still being handed out
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("request taken during an expiry run");

  // A known request keeps the block busy in the next cycle
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready &&
      (s_axis_tuser == ACT_WATCH || s_axis_tuser == ACT_REMOVE ||
       s_axis_tuser == ACT_TICK) |=> !s_axis_tready)
    else $error("ready right after a request was taken");

  // An empty table reports a zero wakeup time
  a_empty_wakeup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[64] |-> m_axis_tdata[63:16] == '0)
    else $error("wakeup time set with nothing watched");

endmodule

bind session_expiry_table sxt_checker u_sxt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: verif/expiry_table_checker.sv
// Checker for the session expiry table: tracks the slot table, predicts every result and compares.
`default_nettype none

module expiry_table_checker #(
  parameter int ENTRIES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [sxt_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic [sxt_pkg::ActW-1:0]     s_axis_tuser,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [sxt_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic [sxt_pkg::StatW-1:0]    m_axis_tuser,
  input  logic                         m_axis_tlast,
  input  logic                         cfg_we_i,
  input  logic [sxt_pkg::YieldW-1:0]   cfg_wdata_i,
  output int                           fail_count_o,
  output int                           outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sxt_pkg::*;

  typedef struct {
    logic [StatW-1:0] status;
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] wakeup;
    logic             wake_valid;
    logic [TimeW-1:0] sleep;
    logic             early;
    logic             last;
  } table_result_t;

  logic              slot_used [ENTRIES];
  logic [KeyW-1:0]   slot_key_m [ENTRIES];
  logic [TimeW-1:0]  slot_exp [ENTRIES];
  logic [TimeW-1:0]  wakeup_mark;
  logic [YieldW-1:0] yield_floor;
  table_result_t     due_results [$];

  function automatic logic earliest_expiry(output logic [TimeW-1:0] when);
    logic any;
    logic [TimeW-1:0] best;
    any  = 1'b0;
    best = TimeMax;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_exp[i] <= best) begin
        best = slot_exp[i];
        any  = 1'b1;
      end
    end
    when = any ? best : '0;
    return any;
  endfunction

  function automatic int find_slot(input logic [KeyW-1:0] key);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_key_m[i] == key) return i;
    end
    return -1;
  endfunction

  task automatic push_result(input logic [StatW-1:0] status, input logic [KeyW-1:0] key,
                             input logic [TimeW-1:0] now, input logic early,
                             input logic last);
    table_result_t r;
    logic [TimeW-1:0] when;
    r.wake_valid = earliest_expiry(when);
    r.status     = status;
    r.key        = key;
    r.wakeup     = when;
    r.sleep      = (r.wake_valid && when > now) ? when - now : '0;
    if (r.sleep < TimeW'(yield_floor)) r.sleep = TimeW'(yield_floor);
    r.early      = early;
    r.last       = last;
    due_results.insert(due_results.size(), r);
  endtask

  task automatic table_apply(input logic [ActW-1:0] act, input logic [KeyW-1:0] key,
                             input logic [TmoW-1:0] tmo, input logic [TimeW-1:0] now);
    logic [TimeW:0]   sum;
    logic [TimeW-1:0] expiry;
    logic [TimeW-1:0] when;
    logic [StatW-1:0] st;
    logic [KeyW-1:0]  hits [$];
    int               slot;
    case (act)
      ACT_WATCH: begin
        sum    = {1'b0, now} + {{(TimeW+1-TmoW){1'b0}}, tmo};
        expiry = sum[TimeW] ? TimeMax : sum[TimeW-1:0];
        slot   = find_slot(key);
        st     = ST_REFRESHED;
        if (slot < 0) begin
          st = ST_INSERTED;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_used[i] && slot < 0) slot = i;
          end
        end
        if (slot < 0) begin
          push_result(ST_FULL, key, now, 1'b0, 1'b1);
        end else begin
          slot_used[slot]  = 1'b1;
          slot_key_m[slot] = key;
          slot_exp[slot]   = expiry;
          push_result(st, key, now, expiry < wakeup_mark, 1'b1);
        end
      end
      ACT_REMOVE: begin
        slot = find_slot(key);
        if (slot >= 0) slot_used[slot] = 1'b0;
        push_result(slot >= 0 ? ST_REMOVED : ST_NOT_FOUND, key, now, 1'b0, 1'b1);
      end
      ACT_TICK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i] && slot_exp[i] <= now) begin
            hits.insert(hits.size(), slot_key_m[i]);
            slot_used[i] = 1'b0;
          end
        end
        // an empty table parks the mark at the top so the next watch wakes early
        wakeup_mark = earliest_expiry(when) ? when : TimeMax;
        if (hits.size() == 0) begin
          push_result(ST_NONE_EXP, '0, now, 1'b0, 1'b1);
        end else begin
          foreach (hits[k]) push_result(ST_EXPIRED, hits[k], now, 1'b0, k == hits.size() - 1);
        end
      end
      default: ;  // unused kind: drop
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fail_count_o++;
      $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t want;
    if (!rst_ni) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      wakeup_mark   = '0;
      yield_floor   = MinYieldReset;
      due_results.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      // results first: they belong to requests taken in earlier cycles
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          fail_count_o++;
          $display("%0t ns: result with nothing due: expected none, actual status %0d key %h",
                   $time, m_axis_tuser, m_axis_tdata[15:0]);
        end else begin
          want = due_results.pop_front();
          check_field("status", 64'(want.status), 64'(m_axis_tuser));
          check_field("key_out", 64'(want.key), 64'(m_axis_tdata[15:0]));
          check_field("next_wakeup_ms", 64'(want.wakeup), 64'(m_axis_tdata[63:16]));
          check_field("next_valid", 64'(want.wake_valid), 64'(m_axis_tdata[64]));
          check_field("sleep_ms", 64'(want.sleep), 64'(m_axis_tdata[112:65]));
          check_field("wake_early", 64'(want.early), 64'(m_axis_tdata[113]));
          check_field("pad", 64'd0, 64'(m_axis_tdata[119:114]));
          check_field("last", 64'(want.last), 64'(m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        table_apply(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16],
                    s_axis_tdata[95:48]);
      end
      if (cfg_we_i) yield_floor = cfg_wdata_i;
      outstanding_o = due_results.size();
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Top of the session expiry table testbench: clock, reset, request and result traffic, verdict.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sxt_pkg::*;

  localparam int ENTRIES        = 32;
  localparam int DRAIN          = 2 * ENTRIES + 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int POOL           = 48;
  localparam int FILL           = ENTRIES + 2;
  localparam logic [ActW-1:0] ACT_UNUSED = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [ActW-1:0]     s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatW-1:0]    m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_we_i;
  logic [YieldW-1:0]   cfg_wdata_i;

  int               fail_count;
  int               outstanding;
  int               idle_cycles;
  int               rx_cycle;
  int               hold_cnt;
  int               stall_cnt;
  int               sent;
  bit               hold_off_req;
  bit               hold_done;
  logic [TimeW-1:0] clock_ms;
  logic [KeyW-1:0]  key_pool [POOL];

  session_expiry_table #(.ENTRIES(ENTRIES)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  expiry_table_checker #(.ENTRIES(ENTRIES)) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // call at a falling edge; returns at the falling edge after the request is taken
  task automatic send_request(input int gap, input logic [ActW-1:0] act,
                              input logic [KeyW-1:0] key, input logic [TmoW-1:0] tmo,
                              input logic [TimeW-1:0] now);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {now, tmo, key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    if (act != ACT_UNUSED) sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    // an unused kind leaves no result, so give the ring time to finish
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic set_yield_floor(input logic [YieldW-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_random(input bit calm);
    int r;
    logic [ActW-1:0] act;
    logic [KeyW-1:0] key;
    logic [TmoW-1:0] tmo;
    r = $urandom_range(0, 99);
    if (r < 50) act = ACT_WATCH;
    else if (r < 66) act = ACT_REMOVE;
    else if (r < 97) act = ACT_TICK;
    else act = ACT_UNUSED;
    key = ($urandom_range(0, 6) == 0) ? KeyW'($urandom) : key_pool[$urandom_range(0, POOL-1)];
    tmo = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 2000);
    if ($urandom_range(0, 39) == 0) clock_ms = TimeW'({$urandom, $urandom});
    else clock_ms = clock_ms + $urandom_range(0, 250);
    send_request(pick_gap(calm), act, key, tmo, clock_ms);
  endtask

  // receiver: random stalls, calm stretches, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_done     = 1'b0;
    hold_cnt      = 0;
    stall_cnt     = 0;
    rx_cycle      = 0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_cycle % 256 >= 64 && $urandom_range(0, 3) == 0) stall_cnt = pick_gap(1'b0);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_TICK;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    hold_off_req  = 1'b0;
    sent          = 0;
    clock_ms      = '0;
    for (int i = 0; i < POOL; i++) key_pool[i] = {10'($urandom), 6'(i)};
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset minimum yield
    send_request(pick_gap(1'b0), ACT_TICK, 16'h0000, 32'd0, 48'd0);
    send_request(pick_gap(1'b0), ACT_REMOVE, 16'h0000, 32'd0, 48'd0);
    send_request(pick_gap(1'b0), ACT_WATCH, 16'h0000, 32'd0, 48'd0);
    send_request(pick_gap(1'b0), ACT_WATCH, 16'hFFFF, 32'hFFFF_FFFF, TimeMax);
    send_request(pick_gap(1'b0), ACT_WATCH, 16'hFFFF, 32'd5, 48'd1000);
    send_request(pick_gap(1'b0), ACT_WATCH, 16'h1234, 32'd500, 48'd1000);
    send_request(pick_gap(1'b0), ACT_UNUSED, 16'hAAAA, 32'h1234_5678, 48'd1100);
    send_request(pick_gap(1'b0), ACT_REMOVE, 16'hFFFF, 32'd0, 48'd1100);
    send_request(pick_gap(1'b0), ACT_REMOVE, 16'hFFFF, 32'd0, 48'd1100);
    send_request(pick_gap(1'b0), ACT_TICK, 16'h0000, 32'd0, 48'd1200);
    send_request(pick_gap(1'b0), ACT_WATCH, 16'h5A5A, 32'hAAAA_AAAA, 48'h5555_5555_5555);
    send_request(pick_gap(1'b0), ACT_WATCH, 16'hA5A5, 32'h5555_5555, 48'hAAAA_AAAA_AAAA);
    send_request(pick_gap(1'b0), ACT_TICK, 16'h0000, 32'd0, 48'd0);
    send_request(pick_gap(1'b0), ACT_TICK, 16'h0000, 32'd0, TimeMax);

    // zero minimum yield: sleep follows the expiry exactly
    set_yield_floor(16'h0000);
    send_request(pick_gap(1'b0), ACT_WATCH, 16'h0007, 32'd0, 48'd50);
    send_request(pick_gap(1'b0), ACT_TICK, 16'h0000, 32'd0, 48'd10);
    send_request(pick_gap(1'b0), ACT_TICK, 16'h0000, 32'd0, 48'd50);
    send_request(pick_gap(1'b0), ACT_TICK, 16'h0000, 32'd0, 48'd60);

    set_yield_floor(16'hFFFF);
    send_request(pick_gap(1'b0), ACT_WATCH, 16'h0008, 32'd10, 48'd100);
    send_request(pick_gap(1'b0), ACT_TICK, 16'h0000, 32'd0, 48'd100);
    send_request(pick_gap(1'b0), ACT_REMOVE, 16'h0008, 32'd0, 48'd100);

    // random traffic, then hold the sender until everything has come back
    set_yield_floor(YieldW'($urandom));
    clock_ms = 48'd2000;
    for (int i = 0; i < 30; i++) send_random(i % 40 < 10);
    wait_drained();

    // fill the table past capacity behind a long receiver hold-off, then expire it all
    set_yield_floor(16'd1);
    hold_off_req = 1'b1;
    send_request(pick_gap(1'b0), ACT_TICK, 16'h0000, 32'd0, TimeMax);
    clock_ms = 48'd1000;
    for (int i = 0; i < FILL; i++) begin
      clock_ms = clock_ms + 1;
      send_request(pick_gap(1'b1), ACT_WATCH, key_pool[i], $urandom_range(0, 100), clock_ms);
    end
    clock_ms = clock_ms + 5000;
    send_request(pick_gap(1'b0), ACT_TICK, 16'h0000, 32'd0, clock_ms);

    set_yield_floor(MinYieldReset);
    for (int i = 0; i < 15; i++) send_random(i >= 10);

    set_yield_floor(YieldW'($urandom));
    for (int i = 0; i < 20; i++) send_random(1'b0);

    wait_drained();
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
